// ===== hw/rtl/vn_pkg.sv =====
// shared widths and constants for the vector normalizer
package vn_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned SQ_W       = 2 * IN_W;
  localparam int unsigned UNIT_W     = FRAC_BITS + 2;
  localparam int unsigned QUO_W      = FRAC_BITS + 1;
  localparam int unsigned SQRT_STEPS = LEN_W;
  localparam int unsigned DIV_STEPS  = FRAC_BITS + 1;
  localparam int unsigned REM_W      = LEN_W + 2;
  localparam int unsigned LANES      = 3;

  localparam int unsigned IN_DATA_W  = ((LANES * IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W  = LANES * UNIT_W + LEN_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [IN_W-1:0]  mag_t;
  typedef logic [SQ_W-1:0]  sq_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [QUO_W-1:0] quo_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

endpackage

// ===== hw/rtl/vec3_normalize.sv =====
// vector normalizer top level: magnitude, square root and per-lane divide pipeline
//
// takes one signed fixed-point 3-vector per word and returns its length (floor of the
// square root of the sum of squares) and the unit vector, each component being
// component * 2^FRAC_BITS / length truncated toward zero. a zero vector returns zero
// length, zero components and tuser set. the pipeline accepts one word every cycle while the
// output is not stalled; a word runs through stages a to c, one stage per square root digit,
// one stage per quotient bit and the output register. a stall at the output freezes the
// whole pipeline, holding every word in place.
module vec3_normalize (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // vec_x, vec_y, vec_z
  input  logic [vn_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // unit_x, unit_y, unit_z, vec_length, zero pad
  output logic [vn_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // zero_length
  output logic                          m_axis_tuser_o
);
  import vn_pkg::*;

  logic en;

  // stage a: magnitudes and signs
  logic                   va_q;
  mag_t                   mag_a_q [LANES];
  logic [LANES-1:0]       neg_a_q;
  // stage b: squares
  logic                   vb_q;
  sq_t                    sq_b_q [LANES];
  mag_t                   mag_b_q [LANES];
  logic [LANES-1:0]       neg_b_q;
  // stage c: sum of squares
  logic                   vc_q;
  sq_t                    sum_c_q;
  mag_t                   mag_c_q [LANES];
  logic [LANES-1:0]       neg_c_q;

  // square root, one digit per stage
  logic                   sv_q    [SQRT_STEPS];
  sq_t                    srad_q  [SQRT_STEPS];
  rem_t                   srem_q  [SQRT_STEPS];
  len_t                   sroot_q [SQRT_STEPS];
  mag_t                   smag_q  [SQRT_STEPS][LANES];
  logic [LANES-1:0]       sneg_q  [SQRT_STEPS];
  sq_t                    srad_d  [SQRT_STEPS];
  rem_t                   srem_d  [SQRT_STEPS];
  len_t                   sroot_d [SQRT_STEPS];

  // divide, one quotient bit per stage in each lane
  logic                   dv_q   [DIV_STEPS];
  len_t                   dr_q   [DIV_STEPS][LANES];
  quo_t                   dq_q   [DIV_STEPS][LANES];
  len_t                   dlen_q [DIV_STEPS];
  logic [LANES-1:0]       dneg_q [DIV_STEPS];
  len_t                   dr_d   [DIV_STEPS][LANES];
  quo_t                   dq_d   [DIV_STEPS][LANES];

  // output register
  logic                   out_valid_q;
  unit_t                  unit_q [LANES];
  len_t                   len_q;
  logic                   zero_q;

  // whole pipeline moves when the output register is free or drained
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // sqrt digit steps
  always_comb begin
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sq_t              rad;
    rem_t             rem;
    len_t             root;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rad  = sum_c_q;
        rem  = '0;
        root = '0;
      end else begin
        rad  = srad_q[k-1];
        rem  = srem_q[k-1];
        root = sroot_q[k-1];
      end
      t     = {rem, rad[SQ_W-1 -: 2]};
      trial = {{2{1'b0}}, root, 2'b01};
      if (t >= trial) begin
        srem_d[k]  = REM_W'(t - trial);
        sroot_d[k] = {root[LEN_W-2:0], 1'b1};
      end else begin
        srem_d[k]  = REM_W'(t);
        sroot_d[k] = {root[LEN_W-2:0], 1'b0};
      end
      srad_d[k] = {rad[SQ_W-3:0], 2'b00};
    end
  end

  // restoring divide steps, the first one takes the magnitude unshifted
  always_comb begin
    logic [LEN_W:0] t;
    logic [LEN_W:0] dlen;
    quo_t           q;
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int l = 0; l < LANES; l++) begin
        if (j == 0) begin
          t    = {1'b0, smag_q[SQRT_STEPS-1][l]};
          dlen = {1'b0, sroot_q[SQRT_STEPS-1]};
          q    = '0;
        end else begin
          t    = {dr_q[j-1][l], 1'b0};
          dlen = {1'b0, dlen_q[j-1]};
          q    = dq_q[j-1][l];
        end
        if (t >= dlen) begin
          dr_d[j][l] = LEN_W'(t - dlen);
          dq_d[j][l] = {q[QUO_W-2:0], 1'b1};
        end else begin
          dr_d[j][l] = LEN_W'(t);
          dq_d[j][l] = {q[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < SQRT_STEPS; k++) sv_q[k] <= 1'b0;
      for (int j = 0; j < DIV_STEPS; j++) dv_q[j] <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      for (int k = 0; k < SQRT_STEPS; k++) sv_q[k] <= (k == 0) ? vc_q : sv_q[k-1];
      dv_q[0] <= sv_q[SQRT_STEPS-1];
      for (int j = 1; j < DIV_STEPS; j++) dv_q[j] <= dv_q[j-1];
      out_valid_q <= dv_q[DIV_STEPS-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        // magnitude of a two's complement component, most negative value fits unsigned
        if (s_axis_tdata_i[l*IN_W + IN_W - 1]) begin
          mag_a_q[l] <= IN_W'(~s_axis_tdata_i[l*IN_W +: IN_W] + 1'b1);
        end else begin
          mag_a_q[l] <= s_axis_tdata_i[l*IN_W +: IN_W];
        end
        neg_a_q[l] <= s_axis_tdata_i[l*IN_W + IN_W - 1];
        sq_b_q[l]  <= mag_a_q[l] * mag_a_q[l];
        mag_b_q[l] <= mag_a_q[l];
        mag_c_q[l] <= mag_b_q[l];
      end
      neg_b_q <= neg_a_q;
      neg_c_q <= neg_b_q;
      sum_c_q <= sq_b_q[0] + sq_b_q[1] + sq_b_q[2];

      for (int k = 0; k < SQRT_STEPS; k++) begin
        srad_q[k]  <= srad_d[k];
        srem_q[k]  <= srem_d[k];
        sroot_q[k] <= sroot_d[k];
        for (int l = 0; l < LANES; l++) begin
          smag_q[k][l] <= (k == 0) ? mag_c_q[l] : smag_q[k-1][l];
        end
        sneg_q[k] <= (k == 0) ? neg_c_q : sneg_q[k-1];
      end

      for (int j = 0; j < DIV_STEPS; j++) begin
        for (int l = 0; l < LANES; l++) begin
          dr_q[j][l] <= dr_d[j][l];
          dq_q[j][l] <= dq_d[j][l];
        end
        dlen_q[j] <= (j == 0) ? sroot_q[SQRT_STEPS-1] : dlen_q[j-1];
        dneg_q[j] <= (j == 0) ? sneg_q[SQRT_STEPS-1] : dneg_q[j-1];
      end

      // sign, and the zero vector case forced to all zeros
      for (int l = 0; l < LANES; l++) begin
        if (dlen_q[DIV_STEPS-1] == '0) begin
          unit_q[l] <= '0;
        end else if (dneg_q[DIV_STEPS-1][l]) begin
          unit_q[l] <= -unit_t'({1'b0, dq_q[DIV_STEPS-1][l]});
        end else begin
          unit_q[l] <= unit_t'({1'b0, dq_q[DIV_STEPS-1][l]});
        end
      end
      len_q  <= dlen_q[DIV_STEPS-1];
      zero_q <= (dlen_q[DIV_STEPS-1] == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = zero_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}},
                            len_q, unit_q[2], unit_q[1], unit_q[0]};

endmodule

// ===== hw/rtl/vn_checker.sv =====
// port-level checks for the vector normalizer, bound to the top level
module vn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [vn_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [vn_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o
);
  import vn_pkg::*;

  localparam logic signed [UNIT_W:0] UNIT_MAX = (UNIT_W+1)'(1) <<< FRAC_BITS;

  // a stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed under stall");

  // zero flag means an all-zero word
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("zero vector with nonzero data");

  // nonzero vector has nonzero length
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[LANES*UNIT_W +: LEN_W] != '0)
    else $error("zero length without zero flag");

  // unit components stay within one
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      $signed(m_axis_tdata_o[0 +: UNIT_W]) <= UNIT_MAX &&
      $signed(m_axis_tdata_o[0 +: UNIT_W]) >= -UNIT_MAX &&
      $signed(m_axis_tdata_o[UNIT_W +: UNIT_W]) <= UNIT_MAX &&
      $signed(m_axis_tdata_o[UNIT_W +: UNIT_W]) >= -UNIT_MAX &&
      $signed(m_axis_tdata_o[2*UNIT_W +: UNIT_W]) <= UNIT_MAX &&
      $signed(m_axis_tdata_o[2*UNIT_W +: UNIT_W]) >= -UNIT_MAX)
    else $error("unit component out of range");

endmodule

bind vec3_normalize vn_checker u_vn_checker (.*);
